[rtl/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a condition at every clock edge outside reset.
`define RGZC_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Checks that a consequence holds in the cycle after its trigger.
`define RGZC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/rgzc_pkg.sv]
`default_nettype none

package rgzc_pkg;

  localparam int NUM_RADARS      = 2;
  localparam int MAX_SPOKE_PX    = 1024;
  localparam int SPOKES_PER_TURN = 4096;

  localparam int ANGLE_W = 12;
  localparam int DEG_W   = 9;
  localparam int RAD_W   = 10;
  localparam int ECHO_W  = 8;
  localparam int LEN_W   = 11;
  localparam int PART_W  = 11;
  localparam int RUN_W   = 21;
  localparam int LATCH_W = 22;
  localparam int CFG_IW  = 3;
  localparam int CFG_DW  = 10;

  localparam int QDEPTH = 4;
  localparam int QAW    = 2;
  localparam int QCW    = 3;

  localparam logic [LEN_W-1:0]  LEN_MAX  = LEN_W'(MAX_SPOKE_PX);
  localparam logic [PART_W-1:0] PART_MAX = '1;
  localparam logic [RUN_W-1:0]  RUN_MAX  = '1;

  typedef enum logic [1:0] {
    ZONE_ARC    = 2'd0,
    ZONE_CIRCLE = 2'd1,
    ZONE_OFF    = 2'd2
  } zone_mode_t;

  typedef enum logic [CFG_IW-1:0] {
    CFG_ZONE_MODE   = 3'd0,
    CFG_ARC_START   = 3'd1,
    CFG_ARC_END     = 3'd2,
    CFG_RANGE_INNER = 3'd3,
    CFG_RANGE_OUTER = 3'd4,
    CFG_ECHO_THRESH = 3'd5
  } cfg_index_t;

  typedef struct packed {
    logic               radar;
    logic [ANGLE_W-1:0] angle;
    logic               hit;
    logic               last;
    logic               zone_fix;
    logic               circle_chk;
  } rgzc_cmd_t;

endpackage

`default_nettype wire

[rtl/rgzc_front.sv]
`default_nettype none

module rgzc_front
  import rgzc_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire logic [CFG_IW-1:0]  cfg_index,
  input  wire logic [CFG_DW-1:0]  cfg_wdata,
  input  wire logic               in_valid,
  input  wire logic               in_radar_sel,
  input  wire logic [ANGLE_W-1:0] in_spoke_angle,
  input  wire logic [DEG_W-1:0]   in_bearing_deg,
  input  wire logic [RAD_W-1:0]   in_pixel_radius,
  input  wire logic [ECHO_W-1:0]  in_echo_value,
  input  wire logic [LEN_W-1:0]   in_spoke_length,
  input  wire logic [RAD_W-1:0]   in_start_radius,
  input  wire logic               in_last_pixel,
  output logic                    cmd_wr,
  output rgzc_cmd_t               cmd
);

  logic [1:0]        mode_r;
  logic [DEG_W-1:0]  arc_start_r;
  logic [DEG_W-1:0]  arc_end_r;
  logic [RAD_W-1:0]  inner_r;
  logic [RAD_W-1:0]  outer_r;
  logic [ECHO_W-1:0] thresh_r;

  logic [LEN_W-1:0] len;
  logic [LEN_W-1:0] len_m1;
  logic [RAD_W-1:0] lo;
  logic [RAD_W-1:0] hi;
  logic             win_ok;
  logic             in_arc;
  logic             counting;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= ZONE_CIRCLE;
      arc_start_r <= '0;
      arc_end_r   <= '0;
      inner_r     <= '0;
      outer_r     <= '0;
      thresh_r    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_ZONE_MODE:   mode_r      <= cfg_wdata[1:0];
        CFG_ARC_START:   arc_start_r <= cfg_wdata[DEG_W-1:0];
        CFG_ARC_END:     arc_end_r   <= cfg_wdata[DEG_W-1:0];
        CFG_RANGE_INNER: inner_r     <= cfg_wdata[RAD_W-1:0];
        CFG_RANGE_OUTER: outer_r     <= cfg_wdata[RAD_W-1:0];
        CFG_ECHO_THRESH: thresh_r    <= cfg_wdata[ECHO_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    len    = (in_spoke_length > LEN_MAX) ? LEN_MAX : in_spoke_length;
    len_m1 = len - LEN_W'(1);
    lo     = (inner_r < in_start_radius) ? in_start_radius : inner_r;
    win_ok = {1'b0, lo} < len;
    hi     = ((len != '0) && ({1'b0, outer_r} > len_m1)) ? len_m1[RAD_W-1:0] : outer_r;

    in_arc = ((in_bearing_deg >= arc_start_r) && (in_bearing_deg < arc_end_r)) ||
             ((arc_start_r >= arc_end_r) &&
              ((in_bearing_deg >= arc_start_r) || (in_bearing_deg < arc_end_r)));

    counting = (mode_r == ZONE_CIRCLE) || ((mode_r == ZONE_ARC) && in_arc);

    cmd.radar      = in_radar_sel;
    cmd.angle      = in_spoke_angle;
    cmd.last       = in_last_pixel;
    cmd.hit        = counting && win_ok && (in_pixel_radius >= lo) &&
                     (in_pixel_radius <= hi) && (in_echo_value >= thresh_r);
    cmd.zone_fix   = (mode_r == ZONE_ARC) && in_arc;
    cmd.circle_chk = (mode_r == ZONE_CIRCLE) && win_ok;

    // Pixels from a radar beyond the configured count are dropped here.
    cmd_wr = in_valid && (int'(in_radar_sel) < NUM_RADARS);
  end

endmodule

`default_nettype wire

[rtl/rgzc_queue.sv]
`default_nettype none

`include "assert_macros.svh"

module rgzc_queue
  import rgzc_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      wr_en,
  input  rgzc_cmd_t      wr_data,
  output logic           full,
  input  wire logic      rd_en,
  output rgzc_cmd_t      rd_data,
  output logic           empty
);

  rgzc_cmd_t        mem_r [QDEPTH];
  logic [QAW-1:0]   wptr_r;
  logic [QAW-1:0]   rptr_r;
  logic [QCW-1:0]   cnt_r;
  logic             do_wr;
  logic             do_rd;

  assign full    = (cnt_r == QCW'(QDEPTH));
  assign empty   = (cnt_r == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem_r[rptr_r];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (do_wr) begin
        wptr_r <= wptr_r + QAW'(1);
      end
      if (do_rd) begin
        rptr_r <= rptr_r + QAW'(1);
      end
      if (do_wr && !do_rd) begin
        cnt_r <= cnt_r + QCW'(1);
      end else if (do_rd && !do_wr) begin
        cnt_r <= cnt_r - QCW'(1);
      end
    end
  end

  `RGZC_ASSERT_ALWAYS(a_q_cnt_bound, cnt_r <= QCW'(QDEPTH), "queue count beyond depth")
  `RGZC_ASSERT_NEXT(a_q_wr_grow, do_wr && !do_rd, cnt_r == $past(cnt_r) + QCW'(1),
                    "queue count did not grow on a lone write")

endmodule

`default_nettype wire

[rtl/rgzc_back.sv]
`default_nettype none

`include "assert_macros.svh"

module rgzc_back
  import rgzc_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  rgzc_cmd_t                cmd,
  input  wire logic                cmd_valid,
  output logic                     cmd_rd,
  input  wire logic                pop,
  output logic                     empty,
  output logic                     out_radar,
  output logic signed [LATCH_W-1:0] out_bogey_total,
  output logic                     out_bogey_updated,
  output logic                     out_spoke_in_zone
);

  logic [PART_W-1:0]  part_r;
  logic [RUN_W-1:0]   run_r   [NUM_RADARS];
  logic [LATCH_W-1:0] latch_r [NUM_RADARS];
  logic               was_r   [NUM_RADARS];
  logic [ANGLE_W-1:0] prev_r  [NUM_RADARS];

  logic               ovalid_r;
  logic               oradar_r;
  logic [LATCH_W-1:0] ototal_r;
  logic               oupd_r;
  logic               ozone_r;

  logic               adv;
  logic               spoke_end;
  logic [PART_W-1:0]  part_eff;
  logic [RUN_W:0]     run_sum;
  logic [RUN_W-1:0]   run_sat;
  logic               in_zone;
  logic               leave;
  logic [LATCH_W-1:0] latch_new;

  always_comb begin
    adv       = cmd_valid && (!cmd.last || !ovalid_r || pop);
    spoke_end = adv && cmd.last;
    part_eff  = (cmd.hit && (part_r != PART_MAX)) ? part_r + PART_W'(1) : part_r;
    run_sum   = {1'b0, run_r[cmd.radar]} + (RUN_W+1)'(part_eff);
    run_sat   = (run_sum > {1'b0, RUN_MAX}) ? RUN_MAX : run_sum[RUN_W-1:0];
    in_zone   = cmd.zone_fix || (cmd.circle_chk && (cmd.angle > prev_r[cmd.radar]));
    leave     = was_r[cmd.radar] && !in_zone;
    latch_new = leave ? {1'b0, run_sat} : latch_r[cmd.radar];
  end

  assign cmd_rd            = adv;
  assign empty             = !ovalid_r;
  assign out_radar         = oradar_r;
  assign out_bogey_total   = $signed(ototal_r);
  assign out_bogey_updated = oupd_r;
  assign out_spoke_in_zone = ozone_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      part_r   <= '0;
      ovalid_r <= 1'b0;
      for (int i = 0; i < NUM_RADARS; i++) begin
        run_r[i]   <= '0;
        latch_r[i] <= '1;
        was_r[i]   <= 1'b0;
        prev_r[i]  <= '0;
      end
    end else begin
      if (adv) begin
        part_r <= cmd.last ? '0 : part_eff;
      end
      if (spoke_end) begin
        run_r[cmd.radar]   <= leave ? '0 : run_sat;
        latch_r[cmd.radar] <= latch_new;
        was_r[cmd.radar]   <= in_zone;
        prev_r[cmd.radar]  <= cmd.angle;
        ovalid_r           <= 1'b1;
      end else if (pop) begin
        ovalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (spoke_end) begin
      oradar_r <= cmd.radar;
      ototal_r <= latch_new;
      oupd_r   <= leave;
      ozone_r  <= in_zone;
    end
  end

  `RGZC_ASSERT_NEXT(a_part_clear, spoke_end, part_r == '0,
                    "spoke accumulator not cleared after spoke end")
  `RGZC_ASSERT_NEXT(a_upd_clears_run, spoke_end && leave,
                    oupd_r && (run_r[oradar_r] == '0),
                    "running count not cleared when a bogey count was latched")

endmodule

`default_nettype wire

[rtl/radar_guard_zone_counter.sv]
// A spoke-ending pixel goes through the queue; when the back end takes it, its result item is registered.
// One pixel per cycle while the queue is not full; a spoke's last pixel waits until the prior result is popped.
// A four-entry queue between the classifier and the back end absorbs result-side stalls.
// Reset is synchronous and active low: zone mode becomes full circle, all other configuration registers zero,
// bogey counts read as -1 and all other per-radar state is cleared at once.
`default_nettype none

module radar_guard_zone_counter
  import rgzc_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IW-1:0]    cfg_index,
  input  wire logic [CFG_DW-1:0]    cfg_wdata,
  input  wire logic                 push,
  output logic                      full,
  input  wire logic                 in_radar_sel,
  input  wire logic [ANGLE_W-1:0]   in_spoke_angle,
  input  wire logic [DEG_W-1:0]     in_bearing_deg,
  input  wire logic [RAD_W-1:0]     in_pixel_radius,
  input  wire logic [ECHO_W-1:0]    in_echo_value,
  input  wire logic [LEN_W-1:0]     in_spoke_length,
  input  wire logic [RAD_W-1:0]     in_start_radius,
  input  wire logic                 in_last_pixel,
  output logic                      empty,
  input  wire logic                 pop,
  output logic                      out_radar,
  output logic signed [LATCH_W-1:0] out_bogey_total,
  output logic                      out_bogey_updated,
  output logic                      out_spoke_in_zone
);

  rgzc_cmd_t wr_cmd;
  rgzc_cmd_t rd_cmd;
  logic      wr_en;
  logic      q_empty;
  logic      rd_en;

  rgzc_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (push && !full),
    .in_radar_sel   (in_radar_sel),
    .in_spoke_angle (in_spoke_angle),
    .in_bearing_deg (in_bearing_deg),
    .in_pixel_radius(in_pixel_radius),
    .in_echo_value  (in_echo_value),
    .in_spoke_length(in_spoke_length),
    .in_start_radius(in_start_radius),
    .in_last_pixel  (in_last_pixel),
    .cmd_wr         (wr_en),
    .cmd            (wr_cmd)
  );

  rgzc_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (wr_en),
    .wr_data(wr_cmd),
    .full   (full),
    .rd_en  (rd_en),
    .rd_data(rd_cmd),
    .empty  (q_empty)
  );

  rgzc_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (rd_cmd),
    .cmd_valid        (!q_empty),
    .cmd_rd           (rd_en),
    .pop              (pop),
    .empty            (empty),
    .out_radar        (out_radar),
    .out_bogey_total  (out_bogey_total),
    .out_bogey_updated(out_bogey_updated),
    .out_spoke_in_zone(out_spoke_in_zone)
  );

endmodule

`default_nettype wire
